FILE: rtl/eit_pkg.sv
// EIT section parser package: word types, result kinds and constants.
// Used by eit_front, eit_back and the top level; depends on nothing.
package eit_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] EitTable     = 8'h4E;
  localparam logic [7:0] TagShort     = 8'h4D;
  localparam logic [7:0] TagComponent = 8'h50;
  localparam logic [7:0] TagParental  = 8'h55;
  localparam logic [11:0] FixedBytes  = 12'd15;
  localparam logic [11:0] EventBytes  = 12'd12;

  typedef enum logic [3:0] {
    KIND_HEADER    = 4'd0,
    KIND_EVENT     = 4'd1,
    KIND_SHORT     = 4'd2,
    KIND_COMPONENT = 4'd3,
    KIND_PARENTAL  = 4'd4,
    KIND_OTHER     = 4'd5,
    KIND_CRC       = 4'd6,
    KIND_REJECT    = 4'd7,
    KIND_LEN_ERR   = 4'd8
  } kind_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        section_start;
    logic [11:0] section_length;
    logic [7:0]  table_kind;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] first_id;
    logic [15:0] second_id;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic [15:0] start_mjd;
    logic [23:0] start_bcd;
    logic [23:0] duration_bcd;
    logic [2:0]  running_state;
    logic        free_ca;
    logic [11:0] loop_length;
    logic [31:0] crc_word;
  } out_word_t;

  // classified word handed from front to back
  typedef struct packed {
    logic       restart;
    logic       reject;
    logic       short_len;
    logic [11:0] event_len;
    logic [7:0] data_byte;
  } cls_word_t;

endpackage

FILE: rtl/eit_fifo.sv
// EIT parser small register queue, generic width.
// Depends on nothing.
module eit_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (do_pop) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= wdata_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth)) else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !empty_o) else $error("queue full and empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("push lost");
endmodule

FILE: rtl/eit_front.sv
// EIT parser front: classifies each accepted byte (start, table check, length).
// Depends on eit_pkg.
module eit_front (
  input  eit_pkg::in_word_t  in_i,
  output eit_pkg::cls_word_t cls_o
);
  always_comb begin
    cls_o.restart   = in_i.section_start;
    cls_o.reject    = in_i.section_start && (in_i.table_kind != eit_pkg::EitTable);
    cls_o.short_len = in_i.section_start && (in_i.section_length < eit_pkg::FixedBytes);
    cls_o.event_len = in_i.section_length - eit_pkg::FixedBytes;
    cls_o.data_byte = in_i.data_byte;
  end
endmodule

FILE: rtl/eit_back.sv
// EIT parser back: phase sequencer, byte collection and result building.
// Depends on eit_pkg.
module eit_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  eit_pkg::cls_word_t cls_i,
  output logic               ready_o,
  output logic               res_valid_o,
  output eit_pkg::out_word_t res_o,
  input  logic               res_ready_i
);
  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_HDR   = 6'b000010,
    PH_EVT   = 6'b000100,
    PH_DHDR  = 6'b001000,
    PH_DBODY = 6'b010000,
    PH_CRC   = 6'b100000
  } phase_e;

  phase_e ph_q, ph_d, ph_w;
  logic [3:0] fc_q, fc_d, fc_n, fc_b;
  logic [11:0] sec_q, sec_d, sec_w;
  logic [11:0] loop_q, loop_d;
  logic [7:0] desc_q, desc_d;
  logic [7:0] held_q [12];
  logic emit;
  eit_pkg::out_word_t res_d;
  logic ov_q, ov_d;
  eit_pkg::out_word_t ov_res_q;
  logic [11:0] evl;
  logic [12:0] need;
  logic [8:0] dsz;

  assign ready_o = !ov_q || res_ready_i;
  assign res_valid_o = ov_q;
  assign res_o = ov_res_q;
  assign fc_b = cls_i.restart ? 4'd0 : fc_q;
  assign fc_n = fc_b + 4'd1;
  assign evl = {held_q[10][3:0], cls_i.data_byte};
  assign need = {1'b0, evl} + {1'b0, eit_pkg::EventBytes};
  assign dsz = {1'b0, cls_i.data_byte} + 9'd2;
  assign ov_d = (valid_i && ready_o && emit) || (ov_q && !res_ready_i);

  function automatic phase_e nxt(input logic [11:0] lr, input logic [11:0] sr);
    if (lr != '0) return PH_DHDR;
    if (sr != '0) return PH_EVT;
    return PH_CRC;
  endfunction

  always_comb begin
    ph_d = ph_q; fc_d = fc_q; sec_d = sec_q; loop_d = loop_q; desc_d = desc_q;
    res_d = '0; emit = 1'b0;
    ph_w = ph_q; sec_w = sec_q;
    if (cls_i.restart) begin
      ph_w = PH_HDR; sec_w = cls_i.event_len;
      fc_d = '0; loop_d = '0; desc_d = '0;
    end
    if (cls_i.restart && (cls_i.reject || cls_i.short_len)) begin
      emit = 1'b1;
      res_d.kind = cls_i.reject ? eit_pkg::KIND_REJECT : eit_pkg::KIND_LEN_ERR;
      ph_d = PH_IDLE; sec_d = '0;
    end else begin
      sec_d = sec_w;
      ph_d = ph_w;
      unique case (ph_w)
        PH_HDR: begin
          fc_d = fc_n;
          if (fc_n >= 4'd6) begin
            emit = 1'b1;
            res_d.kind = eit_pkg::KIND_HEADER;
            res_d.first_id = {held_q[0], held_q[1]};
            res_d.second_id = {held_q[2], held_q[3]};
            res_d.byte_a = held_q[4];
            res_d.byte_b = cls_i.data_byte;
            fc_d = '0;
            ph_d = nxt(loop_d, sec_w);
          end
        end
        PH_EVT: begin
          fc_d = fc_n;
          if (fc_n >= 4'd12) begin
            emit = 1'b1; fc_d = '0;
            if (need > {1'b0, sec_w}) begin
              res_d.kind = eit_pkg::KIND_LEN_ERR;
              ph_d = PH_IDLE; sec_d = '0; loop_d = '0; desc_d = '0;
            end else begin
              sec_d = sec_w - need[11:0];
              loop_d = evl;
              res_d.kind = eit_pkg::KIND_EVENT;
              res_d.first_id = {held_q[0], held_q[1]};
              res_d.start_mjd = {held_q[2], held_q[3]};
              res_d.start_bcd = {held_q[4], held_q[5], held_q[6]};
              res_d.duration_bcd = {held_q[7], held_q[8], held_q[9]};
              res_d.running_state = held_q[10][7:5];
              res_d.free_ca = held_q[10][4];
              res_d.loop_length = evl;
              ph_d = nxt(evl, sec_d);
            end
          end
        end
        PH_DHDR: begin
          fc_d = fc_n;
          if (fc_n >= 4'd2) begin
            emit = 1'b1; fc_d = '0;
            if ({3'b0, dsz} > loop_q) begin
              res_d.kind = eit_pkg::KIND_LEN_ERR;
              ph_d = PH_IDLE; sec_d = '0; loop_d = '0; desc_d = '0;
            end else begin
              loop_d = loop_q - {3'b0, dsz};
              desc_d = cls_i.data_byte;
              priority if (held_q[0] == eit_pkg::TagShort) res_d.kind = eit_pkg::KIND_SHORT;
              else if (held_q[0] == eit_pkg::TagComponent)
                res_d.kind = eit_pkg::KIND_COMPONENT;
              else if (held_q[0] == eit_pkg::TagParental)
                res_d.kind = eit_pkg::KIND_PARENTAL;
              else res_d.kind = eit_pkg::KIND_OTHER;
              res_d.byte_a = held_q[0];
              res_d.byte_b = cls_i.data_byte;
              ph_d = (cls_i.data_byte != '0) ? PH_DBODY : nxt(loop_d, sec_w);
            end
          end
        end
        PH_DBODY: begin
          if (desc_q != '0) desc_d = desc_q - 8'd1;
          if (desc_d == '0) ph_d = nxt(loop_q, sec_w);
        end
        PH_CRC: begin
          fc_d = fc_n;
          if (fc_n >= 4'd4) begin
            emit = 1'b1;
            res_d.kind = eit_pkg::KIND_CRC;
            res_d.crc_word = {held_q[0], held_q[1], held_q[2], cls_i.data_byte};
            ph_d = PH_IDLE; fc_d = '0; sec_d = '0; loop_d = '0; desc_d = '0;
          end
        end
        PH_IDLE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; fc_q <= '0; sec_q <= '0; loop_q <= '0; desc_q <= '0;
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
      if (valid_i && ready_o) begin
        ph_q <= ph_d; fc_q <= fc_d; sec_q <= sec_d; loop_q <= loop_d; desc_q <= desc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      if (ph_w != PH_IDLE && ph_w != PH_DBODY) held_q[fc_b] <= cls_i.data_byte;
      if (emit) ov_res_q <= res_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(ph_q)) else $error("phase not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !res_ready_i |=> ov_q && $stable(ov_res_q)) else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == PH_IDLE |-> loop_q == '0 && desc_q == '0) else $error("idle with residue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q < 4'd12) else $error("field counter overrun");
endmodule

FILE: rtl/eit_section_parser_top.sv
// EIT section parser top level: classifier, input queue, sequencer, output queue.
// Depends on eit_pkg, eit_fifo, eit_front and eit_back.
//
// Input channel: push with in_i (byte, start flag, section length, table id);
// a word is taken when push is high and full low. Bytes start after the
// common section header, section_start marks the first byte of each section.
// Result channel: while empty is low the oldest result sits on out_o and
// leaves when pop is high. At most one result per byte: header after 6
// bytes, event after 12, descriptor after its 2 header bytes, CRC after 4,
// reject or short-section length error at once on the start byte.
// Throughput is one byte per cycle while the output queue has room.
// The edge that takes a result's last byte loads the sequencer's result
// register; from there the result moves into the output queue. When the
// receiver stalls the output queue fills, the sequencer holds its result
// register, then the input queue fills and full rises. Reset empties both
// queues and returns the parser to idle.
module eit_section_parser_top #(
  parameter int unsigned QueueDepth = eit_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  eit_pkg::in_word_t  in_i,
  output logic               full,
  input  logic               pop,
  output eit_pkg::out_word_t out_o,
  output logic               empty
);
  eit_pkg::cls_word_t cls;
  eit_pkg::cls_word_t q_cls;
  eit_pkg::out_word_t res;
  logic q_empty, b_ready, r_valid, o_full;

  eit_front u_front (.in_i(in_i), .cls_o(cls));

  eit_fifo #(.Width($bits(eit_pkg::cls_word_t)), .Depth(QueueDepth)) u_in_q (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(cls), .full_o(full),
    .pop_i(b_ready), .rdata_o(q_cls), .empty_o(q_empty)
  );

  eit_back u_back (
    .clk_i, .rst_ni, .valid_i(!q_empty), .cls_i(q_cls), .ready_o(b_ready),
    .res_valid_o(r_valid), .res_o(res), .res_ready_i(!o_full)
  );

  eit_fifo #(.Width($bits(eit_pkg::out_word_t)), .Depth(QueueDepth)) u_out_q (
    .clk_i, .rst_ni, .push_i(r_valid), .wdata_i(res), .full_o(o_full),
    .pop_i(pop), .rdata_o(out_o), .empty_o(empty)
  );
endmodule

FILE: tb/tb_eit_section_parser_top.sv
// Self-checking bench for eit_section_parser_top: directed table, then random sections.
// Depends on eit_pkg and the parser RTL; results are checked against an in-bench predictor.
module tb_eit_section_parser_top;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned RandomItems = 1350;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_HDR   = 6'b000010,
    PH_EVT   = 6'b000100,
    PH_DHDR  = 6'b001000,
    PH_DBODY = 6'b010000,
    PH_CRC   = 6'b100000
  } phase_e;

  typedef struct {
    eit_pkg::in_word_t  word;
    logic               typed;
    eit_pkg::out_word_t res;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  eit_pkg::in_word_t  in_i = '0;
  logic               full;
  logic               pop = 1'b0;
  eit_pkg::out_word_t out_o;
  logic               empty;

  eit_pkg::out_word_t expected_q[$];
  eit_pkg::in_word_t  byte_q[$];
  dir_row_t  dir_rows[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  logic      stim_done = 1'b0;
  logic      no_idle = 1'b0;
  logic      hold_off = 1'b0;
  int unsigned accepted = 0;

  phase_e      ph;
  logic [3:0]  cnt;
  logic [11:0] sec_rem;
  logic [11:0] loop_rem;
  logic [8:0]  desc_rem;
  logic [7:0]  held[12];

  eit_section_parser_top u_dut (
    .clk_i, .rst_ni, .push, .in_i, .full, .pop, .out_o, .empty
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic phase_e after_group();
    if (loop_rem != 0) return PH_DHDR;
    if (sec_rem != 0) return PH_EVT;
    return PH_CRC;
  endfunction

  function automatic void parser_idle();
    ph = PH_IDLE;
    cnt = '0;
    sec_rem = '0;
    loop_rem = '0;
    desc_rem = '0;
  endfunction

  // predict the result of one byte; returns 1 when a result is due
  function automatic logic predict_parse(input eit_pkg::in_word_t w,
                                         output eit_pkg::out_word_t r);
    logic [11:0] lp;
    logic [8:0]  sz;
    r = '0;
    if (w.section_start) begin
      parser_idle();
      if (w.table_kind != eit_pkg::EitTable) begin
        r.kind = eit_pkg::KIND_REJECT;
        return 1'b1;
      end
      if (w.section_length < eit_pkg::FixedBytes) begin
        r.kind = eit_pkg::KIND_LEN_ERR;
        return 1'b1;
      end
      sec_rem = w.section_length - eit_pkg::FixedBytes;
      ph = PH_HDR;
    end
    case (ph)
      PH_HDR: begin
        held[cnt] = w.data_byte;
        cnt++;
        if (cnt < 6) return 1'b0;
        r.kind = eit_pkg::KIND_HEADER;
        r.first_id = {held[0], held[1]};
        r.second_id = {held[2], held[3]};
        r.byte_a = held[4];
        r.byte_b = held[5];
        cnt = '0;
        ph = after_group();
        return 1'b1;
      end
      PH_EVT: begin
        held[cnt] = w.data_byte;
        cnt++;
        if (cnt < 12) return 1'b0;
        lp = {held[10][3:0], held[11]};
        cnt = '0;
        if ({1'b0, lp} + 13'd12 > {1'b0, sec_rem}) begin
          parser_idle();
          r.kind = eit_pkg::KIND_LEN_ERR;
          return 1'b1;
        end
        sec_rem -= lp + eit_pkg::EventBytes;
        loop_rem = lp;
        r.kind = eit_pkg::KIND_EVENT;
        r.first_id = {held[0], held[1]};
        r.start_mjd = {held[2], held[3]};
        r.start_bcd = {held[4], held[5], held[6]};
        r.duration_bcd = {held[7], held[8], held[9]};
        r.running_state = held[10][7:5];
        r.free_ca = held[10][4];
        r.loop_length = lp;
        ph = after_group();
        return 1'b1;
      end
      PH_DHDR: begin
        held[cnt] = w.data_byte;
        cnt++;
        if (cnt < 2) return 1'b0;
        sz = {1'b0, held[1]} + 9'd2;
        cnt = '0;
        if ({4'd0, sz} > {1'b0, loop_rem}) begin
          parser_idle();
          r.kind = eit_pkg::KIND_LEN_ERR;
          return 1'b1;
        end
        loop_rem -= {3'd0, sz};
        desc_rem = {1'b0, held[1]};
        case (held[0])
          eit_pkg::TagShort:     r.kind = eit_pkg::KIND_SHORT;
          eit_pkg::TagComponent: r.kind = eit_pkg::KIND_COMPONENT;
          eit_pkg::TagParental:  r.kind = eit_pkg::KIND_PARENTAL;
          default:               r.kind = eit_pkg::KIND_OTHER;
        endcase
        r.byte_a = held[0];
        r.byte_b = held[1];
        ph = (desc_rem != 0) ? PH_DBODY : after_group();
        return 1'b1;
      end
      PH_DBODY: begin
        if (desc_rem != 0) desc_rem--;
        if (desc_rem == 0) ph = after_group();
        return 1'b0;
      end
      PH_CRC: begin
        held[cnt] = w.data_byte;
        cnt++;
        if (cnt < 4) return 1'b0;
        r.kind = eit_pkg::KIND_CRC;
        r.crc_word = {held[0], held[1], held[2], held[3]};
        parser_idle();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic eit_pkg::in_word_t mk(input logic [7:0] b, input logic s = 1'b0,
                                           input logic [11:0] l = '0,
                                           input logic [7:0] t = eit_pkg::EitTable);
    eit_pkg::in_word_t w;
    w.data_byte = b;
    w.section_start = s;
    w.section_length = l;
    w.table_kind = t;
    return w;
  endfunction

  task automatic add_row(input eit_pkg::in_word_t w, input logic typed = 1'b0,
                         input eit_pkg::kind_e k = eit_pkg::KIND_HEADER);
    dir_row_t d;
    d.word = w;
    d.typed = typed;
    d.res = '0;
    d.res.kind = k;
    dir_rows.insert(dir_rows.size(), d);
  endtask

  // build one well-formed section (occasionally broken) with random content
  task automatic gen_section();
    int unsigned nev, nd, dl, body;
    logic [7:0] sec[$];
    logic [7:0] evt[$];
    logic [7:0] tags[4];
    logic [11:0] lp;
    eit_pkg::in_word_t w;
    tags = '{eit_pkg::TagShort, eit_pkg::TagComponent, eit_pkg::TagParental, 8'h00};
    body = 0;
    nev = $urandom_range(0, 3);
    for (int unsigned e = 0; e < nev; e++) begin
      evt = {};
      nd = $urandom_range(0, 3);
      for (int unsigned d = 0; d < nd; d++) begin
        tags[3] = 8'($urandom);
        evt.insert(evt.size(), tags[$urandom_range(0, 3)]);
        dl = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
        evt.insert(evt.size(), dl[7:0]);
        for (int unsigned k = 0; k < dl; k++) evt.insert(evt.size(), 8'($urandom));
      end
      lp = 12'(evt.size());
      if ($urandom_range(0, 19) == 0) lp = 12'(lp + $urandom_range(1, 3));
      for (int k = 0; k < 10; k++) sec.insert(sec.size(), 8'($urandom));
      sec.insert(sec.size(), {sec[$][7:4], lp[11:8]});
      sec.insert(sec.size(), lp[7:0]);
      sec = {sec, evt};
      body += 12 + evt.size();
    end
    for (int k = 0; k < 4; k++) sec.insert(sec.size(), 8'($urandom));
    for (int k = 0; k < 6; k++) sec.push_front(8'($urandom));
    w = mk(sec[0], 1'b1, 12'(body + 15));
    if ($urandom_range(0, 24) == 0) w.table_kind = 8'($urandom);
    if ($urandom_range(0, 24) == 0) w.section_length = 12'($urandom_range(0, 14));
    if ($urandom_range(0, 24) == 0) w.section_length = 12'($urandom);
    byte_q.insert(byte_q.size(), w);
    for (int unsigned k = 1; k < sec.size(); k++) begin
      if ($urandom_range(0, 99) == 0) break;
      w = mk(sec[k]);
      w.section_length = 12'($urandom);
      w.table_kind = 8'($urandom);
      byte_q.insert(byte_q.size(), w);
    end
    if ($urandom_range(0, 9) == 0)
      for (int k = $urandom_range(1, 4); k > 0; k--)
        byte_q.insert(byte_q.size(), mk(8'($urandom)));
  endtask

  task automatic send(input eit_pkg::in_word_t w, input logic typed,
                      input eit_pkg::out_word_t tr);
    eit_pkg::out_word_t r;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    accepted++;
    if (predict_parse(w, r)) begin
      if (typed && r != tr) begin
        $error("directed row kind: expected %0d, actual %0d", tr.kind, r.kind);
        errors++;
      end
      expected_q.insert(expected_q.size(), r);
    end
  endtask

  initial begin
    eit_pkg::out_word_t none;
    none = '0;
    parser_idle();
    for (int k = 0; k < 12; k++) held[k] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    add_row(mk(8'hFF), 1'b0);
    add_row(mk(8'h00, 1'b1, 12'd15, 8'h00), 1'b1, eit_pkg::KIND_REJECT);
    add_row(mk(8'hFF, 1'b1, 12'd4093, 8'hFF), 1'b1, eit_pkg::KIND_REJECT);
    add_row(mk(8'h00, 1'b1, 12'd14), 1'b1, eit_pkg::KIND_LEN_ERR);
    add_row(mk(8'h00, 1'b1, 12'd0), 1'b1, eit_pkg::KIND_LEN_ERR);
    add_row(mk(8'hFF, 1'b1, 12'd15));
    for (int k = 0; k < 5; k++) add_row(mk(8'(8'hFF - k)));
    for (int k = 0; k < 4; k++) add_row(mk(8'(8'hA5 + k)));
    add_row(mk(8'h12, 1'b1, 12'd27));
    for (int k = 0; k < 5; k++) add_row(mk(8'h00));
    for (int k = 0; k < 10; k++) add_row(mk(8'(8'hF0 | k)));
    add_row(mk(8'hFF));
    add_row(mk(8'h00));
    foreach (dir_rows[i]) send(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res);
    while (accepted < RandomItems + dir_rows.size()) begin
      if (byte_q.size() == 0) gen_section();
      if (accepted > dir_rows.size() + RandomItems - 150) no_idle <= 1'b1;
      send(byte_q.pop_front(), 1'b0, none);
    end
    push <= 1'b0;
    stim_done <= 1'b1;
  end

  initial begin
    wait (rst_ni);
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (60) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (hold_off) begin
      pop <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_q.size() == 0) begin
        $error("unexpected word: kind %0d", out_o.kind);
        errors++;
      end else begin
        automatic eit_pkg::out_word_t e = expected_q.pop_front();
        if (e.kind != out_o.kind) $error("kind: exp %0d act %0d", e.kind, out_o.kind);
        if (e.first_id != out_o.first_id)
          $error("first_id: exp %h act %h", e.first_id, out_o.first_id);
        if (e.second_id != out_o.second_id)
          $error("second_id: exp %h act %h", e.second_id, out_o.second_id);
        if (e.byte_a != out_o.byte_a) $error("byte_a: exp %h act %h", e.byte_a, out_o.byte_a);
        if (e.byte_b != out_o.byte_b) $error("byte_b: exp %h act %h", e.byte_b, out_o.byte_b);
        if (e.start_mjd != out_o.start_mjd)
          $error("start_mjd: exp %h act %h", e.start_mjd, out_o.start_mjd);
        if (e.start_bcd != out_o.start_bcd)
          $error("start_bcd: exp %h act %h", e.start_bcd, out_o.start_bcd);
        if (e.duration_bcd != out_o.duration_bcd)
          $error("duration_bcd: exp %h act %h", e.duration_bcd, out_o.duration_bcd);
        if (e.running_state != out_o.running_state)
          $error("running_state: exp %h act %h", e.running_state, out_o.running_state);
        if (e.free_ca != out_o.free_ca)
          $error("free_ca: exp %h act %h", e.free_ca, out_o.free_ca);
        if (e.loop_length != out_o.loop_length)
          $error("loop_length: exp %h act %h", e.loop_length, out_o.loop_length);
        if (e.crc_word != out_o.crc_word)
          $error("crc_word: exp %h act %h", e.crc_word, out_o.crc_word);
        if (e != out_o) errors++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stim_done);
    while (expected_q.size() != 0 && idle_cycles < StallLimit) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_q.size() == 0 && errors == 0 && empty) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    wait (rst_ni);
    wait (idle_cycles >= StallLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: eit_section_parser_top.f
rtl/eit_pkg.sv
rtl/eit_fifo.sv
rtl/eit_front.sv
rtl/eit_back.sv
rtl/eit_section_parser_top.sv
tb/tb_eit_section_parser_top.sv
